// File: rtl/core/snappy_pkg.sv
// ----------------------------------------------------------------------------
// Snappy decompressor package
// Shared constants and status codes for the raw snappy stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package snappy_pkg;
	localparam int unsigned MaxLenDefault   = 30'd536870912;
	localparam int unsigned HistDepthDefault = 65536;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC     = 3'd1,
		ST_BAD_OFF   = 3'd2,
		ST_LEN_MISM  = 3'd3,
		ST_BAD_HDR   = 3'd4
	} status_t;
endpackage
`default_nettype wire

// File: rtl/core/snappy_hist.sv
// ----------------------------------------------------------------------------
// Snappy history store
// One write port, one registered read port over the produced-byte window.
// ----------------------------------------------------------------------------
`default_nettype none
module snappy_hist #(
	parameter int unsigned AW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/snappy_stream_decompressor.sv
// ----------------------------------------------------------------------------
// Snappy raw stream decompressor
// Decodes one compressed byte per item into zero to 64 decoded bytes.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tdata=in_byte, tlast=in_last
// m_axis    out  tvalid/tready      tdata=out_byte, tuser=flags/status
// cfg       in   cfg_valid/ready    cfg_data=max_output_length
// A header, tag or length byte is only accepted; a literal byte, or a byte that
// ends the stream without decoding one, is accepted, then presented.
// A copy is accepted, then each of its bytes is read from history, captured
// and presented.
// Reset clears control state; history is read only where written.
// The input is stalled while a result waits on m_axis.
`default_nettype none
module snappy_stream_decompressor
	import snappy_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = HistDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // in_byte
	input  wire logic        s_axis_tlast,   // in_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // out_byte
	output logic [5:0]       m_axis_tuser,   // byte_valid, run_last, stream_done, status[2:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [29:0] cfg_data        // max_output_length
);
	localparam int unsigned AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		PH_HEADER, PH_TAG, PH_LITLEN, PH_LITERAL, PH_OFFSET, PH_DRAIN
	} phase_t;
	typedef enum logic [1:0] {S_IN, S_OUT, S_COPY, S_COPYW} seq_t;

	phase_t      phase_q;
	seq_t        seq_q;
	logic [29:0] maxlen_q;
	logic [63:0] decl_q;
	logic [3:0]  hidx_q;
	logic [29:0] prod_q;
	logic [7:0]  tag_q;
	logic [2:0]  xleft_q;
	logic [31:0] acc_q;
	logic [32:0] litleft_q;
	logic [6:0]  clen_q;
	logic [AW-1:0] cptr_q;
	logic        cdone_q;
	logic [2:0]  cst_q;
	logic [7:0]  ob_q;
	logic [5:0]  ou_q;

	logic        we;
	logic [7:0]  we_data;
	logic [AW-1:0] raddr;
	logic [7:0]  rdata;

	snappy_hist #(.AW(AW)) u_hist (
		.clk, .we, .waddr(prod_q[AW-1:0]), .wdata(we_data), .raddr, .rdata
	);

	assign cfg_ready = (seq_q == S_IN) && !m_axis_tvalid;
	assign s_axis_tready = (seq_q == S_IN) && !m_axis_tvalid;
	assign m_axis_tvalid = (seq_q == S_OUT);
	assign m_axis_tdata = ob_q;
	assign m_axis_tuser = ou_q;
	assign raddr = cptr_q;

	// combinational decode of one accepted byte
	logic [2:0]  ext;
	logic [63:0] dsh;
	logic [32:0] clen_c;
	logic [31:0] off_c;
	logic [31:0] acc_n;
	logic [1:0]  pos;
	always_comb begin
		case (tag_q[1:0])
			2'd0:    ext = 3'(tag_q[7:2] - 6'd59);
			2'd1:    ext = 3'd1;
			2'd2:    ext = 3'd2;
			default: ext = 3'd4;
		endcase
		pos = 2'(ext - xleft_q);
		acc_n = acc_q | (32'(s_axis_tdata) << {pos, 3'b000});
		dsh = 64'(s_axis_tdata[6:0]) << (7 * hidx_q);
		if (tag_q[1:0] == 2'd1) begin
			clen_c = 33'(tag_q[4:2]) + 33'd4;
			off_c = {21'd0, tag_q[7:5], acc_n[7:0]};
		end else begin
			clen_c = 33'(tag_q[7:2]) + 33'd1;
			off_c = acc_n;
		end
	end

	assign we = (seq_q == S_IN && s_axis_tvalid && s_axis_tready && phase_q == PH_LITERAL)
		|| (seq_q == S_COPYW);
	assign we_data = (seq_q == S_COPYW) ? rdata : s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		logic        emit, done, lst;
		logic [2:0]  st;
		phase_t      ph;
		logic [63:0] d;
		if (!arst_n) begin
			phase_q <= PH_HEADER; seq_q <= S_IN; maxlen_q <= 30'(MaxLenDefault);
			decl_q <= '0; hidx_q <= '0; prod_q <= '0; tag_q <= '0; xleft_q <= '0;
			acc_q <= '0; litleft_q <= '0; clen_q <= '0; cptr_q <= '0;
			cdone_q <= 1'b0; cst_q <= ST_OK; ob_q <= '0; ou_q <= '0;
		end else begin
			case (seq_q)
			S_IN: begin
				if (cfg_valid && cfg_ready)
					maxlen_q <= cfg_data;
				if (s_axis_tvalid && s_axis_tready) begin
					emit = 1'b0; done = 1'b0; st = ST_OK; ph = phase_q;
					lst = s_axis_tlast; d = decl_q;
					case (phase_q)
					PH_HEADER: begin
						d = decl_q | dsh;
						decl_q <= d;
						hidx_q <= hidx_q + 4'd1;
						if (!s_axis_tdata[7] || hidx_q == 4'd9) begin
							if (d > 64'(maxlen_q)) begin done = 1'b1; st = ST_BAD_HDR; end
							else ph = PH_TAG;
						end
					end
					PH_TAG: begin
						tag_q <= s_axis_tdata;
						acc_q <= '0;
						if (s_axis_tdata[1:0] == 2'd0) begin
							if (s_axis_tdata[7:2] < 6'd60) begin
								if (64'(prod_q) + 64'(s_axis_tdata[7:2]) + 64'd1 > decl_q) begin
									done = 1'b1; st = ST_LEN_MISM;
								end else begin
									litleft_q <= 33'(s_axis_tdata[7:2]) + 33'd1;
									ph = PH_LITERAL;
								end
							end else begin
								xleft_q <= 3'(s_axis_tdata[7:2] - 6'd59);
								ph = PH_LITLEN;
							end
						end else begin
							xleft_q <= (s_axis_tdata[1:0] == 2'd1) ? 3'd1 :
								((s_axis_tdata[1:0] == 2'd2) ? 3'd2 : 3'd4);
							ph = PH_OFFSET;
						end
					end
					PH_LITLEN, PH_OFFSET: begin
						acc_q <= acc_n;
						xleft_q <= xleft_q - 3'd1;
						if (xleft_q == 3'd1) begin
							if (phase_q == PH_LITLEN) begin
								if (64'(prod_q) + 64'(acc_n) + 64'd1 > decl_q) begin
									done = 1'b1; st = ST_LEN_MISM;
								end else begin
									litleft_q <= 33'(acc_n) + 33'd1;
									ph = PH_LITERAL;
								end
							end else if (off_c == 32'd0 || off_c > 32'(prod_q)
								|| 33'(off_c) > 33'(HISTORY_DEPTH)) begin
								done = 1'b1; st = ST_BAD_OFF;
							end else if (64'(prod_q) + 64'(clen_c) > decl_q) begin
								done = 1'b1; st = ST_LEN_MISM;
							end else begin
								ph = PH_TAG;
								clen_q <= 7'(clen_c);
								cptr_q <= AW'(prod_q - off_c[29:0]);
							end
						end
					end
					PH_LITERAL: begin
						emit = 1'b1;
						prod_q <= prod_q + 30'd1;
						litleft_q <= litleft_q - 33'd1;
						if (litleft_q == 33'd1) ph = PH_TAG;
					end
					default: ;
					endcase
					if (done) ph = PH_DRAIN;
					if (lst && phase_q != PH_DRAIN && !done) begin
						done = 1'b1;
						// a copy that closes the stream counts its own bytes
						if (ph == PH_TAG)
							st = (64'(prod_q) + 64'(emit)
								+ ((phase_q == PH_OFFSET) ? 64'(clen_c) : 64'd0) == d)
								? ST_OK : ST_LEN_MISM;
						else
							st = ST_TRUNC;
					end
					phase_q <= ph;
					if (phase_q == PH_OFFSET && xleft_q == 3'd1 && ph == PH_TAG) begin
						seq_q <= S_COPY; cdone_q <= done; cst_q <= st;
					end else if (emit || (done && phase_q != PH_DRAIN)) begin
						seq_q <= S_OUT; ob_q <= emit ? s_axis_tdata : 8'd0;
						ou_q <= {st, done, 1'b1, emit};
					end
					if (lst) begin
						phase_q <= PH_HEADER; decl_q <= '0; hidx_q <= '0;
						if (!(phase_q == PH_OFFSET && xleft_q == 3'd1 && ph == PH_TAG))
							prod_q <= '0;
						tag_q <= '0; xleft_q <= '0; acc_q <= '0; litleft_q <= '0;
					end
				end
			end
			S_COPY: seq_q <= S_COPYW;
			S_COPYW: begin
				ob_q <= rdata;
				ou_q <= (clen_q == 7'd1) ? {cst_q, cdone_q, 1'b1, 1'b1} : 6'b000001;
				prod_q <= prod_q + 30'd1;
				cptr_q <= cptr_q + AW'(1);
				clen_q <= clen_q - 7'd1;
				seq_q <= S_OUT;
			end
			S_OUT: begin
				if (m_axis_tready) begin
					if (clen_q != 7'd0 && ou_q[1] == 1'b0) seq_q <= S_COPY;
					else begin
						seq_q <= S_IN; clen_q <= '0;
						if (ou_q[2]) prod_q <= '0;
					end
				end
			end
			default: seq_q <= S_IN;
			endcase
		end
	end

	a_in_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != S_IN) |-> !s_axis_tready) else $error("input open during work");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1]) else $error("done not last");
	a_stat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tuser[5:3] == ST_OK))
		else $error("status without done");
endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Snappy stream decompressor testbench
// Feeds directed and random compressed streams, valid, corrupted and noise,
// predicts the decoded bytes and end status of every stream, and checks
// each output item in order under random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import snappy_pkg::*;

	typedef enum logic [2:0] {
		DP_HEADER, DP_TAG, DP_LITLEN, DP_LITERAL, DP_OFFSET, DP_DRAIN
	} dec_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} comp_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       run_last;
		logic       done;
		status_t    st;
	} dec_out_t;

	localparam int unsigned HistDepth = 65536;
	localparam int unsigned SettleCycles = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // in_byte
	logic        s_axis_tlast = 1'b0;   // in_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // out_byte
	logic [5:0]  m_axis_tuser;          // byte_valid, run_last, stream_done, status[2:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [29:0] cfg_data = 30'd0;

	snappy_stream_decompressor i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// decoder shadow state
	logic [29:0]       max_len;
	dec_phase_t        ph;
	longint unsigned   hdr_len;
	int unsigned       hdr_idx;
	int unsigned       produced;
	logic [7:0]        tag;
	int unsigned       extra_left;
	logic [31:0]       acc;
	longint unsigned   lit_left;
	logic [7:0]        hist [0:HistDepth-1];

	comp_byte_t pending_bytes [$];
	dec_out_t   expected_bytes [$];
	dec_out_t   step_out [$];

	int  fails = 0;
	int  n_in = 0;
	int  n_out = 0;
	int  n_streams = 0;
	bit  in_took = 0;
	int  in_gap = 0;
	int  rx_gap = 0;
	int  hold_cnt = 0;
	bit  hold_req = 0;
	bit  calm = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void restart_stream();
		ph = DP_HEADER;
		hdr_len = 0;
		hdr_idx = 0;
		produced = 0;
		tag = 8'd0;
		extra_left = 0;
		acc = 32'd0;
		lit_left = 0;
	endfunction

	function automatic void emit(logic [7:0] v);
		dec_out_t r;
		r.data = v;
		r.valid = 1'b1;
		r.run_last = 1'b0;
		r.done = 1'b0;
		r.st = ST_OK;
		step_out.insert(step_out.size(), r);
		hist[produced % HistDepth] = v;
		produced++;
	endfunction

	function automatic int unsigned extra_total();
		case (tag[1:0])
			2'd0: return (int'(tag) >> 2) - 59;
			2'd1: return 1;
			2'd2: return 2;
			default: return 4;
		endcase
	endfunction

	function automatic status_t start_lit(longint unsigned n);
		if (longint'(produced) + n > hdr_len)
			return ST_LEN_MISM;
		lit_left = n;
		ph = DP_LITERAL;
		return ST_OK;
	endfunction

	function automatic status_t run_copy();
		int unsigned len;
		int unsigned off;
		if (tag[1:0] == 2'd1) begin
			len = int'(tag[4:2]) + 4;
			off = (int'(tag[7:5]) << 8) | int'(acc[7:0]);
		end else begin
			len = (int'(tag) >> 2) + 1;
			off = acc;
		end
		if (off == 0 || off > produced || off > HistDepth)
			return ST_BAD_OFF;
		if (longint'(produced) + len > hdr_len)
			return ST_LEN_MISM;
		for (int i = 0; i < len; i++)
			emit(hist[(produced - off) % HistDepth]);
		ph = DP_TAG;
		return ST_OK;
	endfunction

	// Predict the output items caused by one compressed byte.
	function automatic void decode_byte(logic [7:0] b, logic last);
		status_t     err;
		status_t     st;
		bit          done;
		bit          was_drain;
		int unsigned pos;
		dec_out_t    r;
		err = ST_OK;
		st = ST_OK;
		done = 0;
		was_drain = (ph == DP_DRAIN);
		step_out.delete();
		case (ph)
			DP_HEADER: begin
				hdr_len |= longint'(b[6:0]) << (7 * hdr_idx);
				hdr_idx++;
				if (!b[7] || hdr_idx >= 10) begin
					if (hdr_len > longint'(max_len))
						err = ST_BAD_HDR;
					else
						ph = DP_TAG;
				end
			end
			DP_TAG: begin
				tag = b;
				acc = 32'd0;
				if (b[1:0] == 2'd0) begin
					if ((int'(b) >> 2) < 60) begin
						err = start_lit(longint'(int'(b) >> 2) + 1);
					end else begin
						extra_left = (int'(b) >> 2) - 59;
						ph = DP_LITLEN;
					end
				end else begin
					extra_left = extra_total();
					ph = DP_OFFSET;
				end
			end
			DP_LITLEN, DP_OFFSET: begin
				pos = (extra_total() - extra_left) & 3;
				acc |= 32'(b) << (8 * pos);
				extra_left = (extra_left - 1) & 7;
				if (extra_left == 0) begin
					if (ph == DP_LITLEN)
						err = start_lit(longint'(acc) + 1);
					else
						err = run_copy();
				end
			end
			DP_LITERAL: begin
				emit(b);
				lit_left--;
				if (lit_left == 0)
					ph = DP_TAG;
			end
			default: ;
		endcase
		if (err != ST_OK) begin
			ph = DP_DRAIN;
			done = 1;
			st = err;
		end
		// bytes swallowed after an error end silently on the last flag
		if (last && was_drain) begin
			restart_stream();
			return;
		end
		if (last) begin
			if (!done) begin
				done = 1;
				if (ph == DP_TAG)
					st = (longint'(produced) == hdr_len) ? ST_OK : ST_LEN_MISM;
				else
					st = ST_TRUNC;
			end
			restart_stream();
		end
		if (done && step_out.size() == 0) begin
			r.data = 8'd0;
			r.valid = 1'b0;
			r.run_last = 1'b0;
			r.done = 1'b0;
			r.st = ST_OK;
			step_out.insert(step_out.size(), r);
		end
		if (step_out.size() > 0) begin
			step_out[$].run_last = 1'b1;
			step_out[$].done = done;
			step_out[$].st = done ? st : ST_OK;
		end
		foreach (step_out[i])
			expected_bytes.insert(expected_bytes.size(), step_out[i]);
	endfunction

	// sampling and checking
	always @(posedge clk) begin
		dec_out_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				in_took = 1;
				n_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_out++;
				if (expected_bytes.size() == 0) begin
					$error("unexpected output item data=%h user=%h", m_axis_tdata, m_axis_tuser);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					if (m_axis_tdata !== want.data) begin
						$error("out_byte expected %h got %h", want.data, m_axis_tdata);
						fails++;
					end
					if (m_axis_tuser[0] !== want.valid) begin
						$error("byte_valid expected %b got %b", want.valid, m_axis_tuser[0]);
						fails++;
					end
					if (m_axis_tuser[1] !== want.run_last) begin
						$error("run_last expected %b got %b", want.run_last, m_axis_tuser[1]);
						fails++;
					end
					if (m_axis_tuser[2] !== want.done) begin
						$error("stream_done expected %b got %b", want.done, m_axis_tuser[2]);
						fails++;
					end
					if (m_axis_tuser[5:3] !== want.st) begin
						$error("status expected %0d got %0d", want.st, m_axis_tuser[5:3]);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				max_len = cfg_data;
		end
	end

	// sender
	always @(negedge clk) begin
		comp_byte_t it;
		if (arst_n && (!s_axis_tvalid || in_took)) begin
			in_took = 0;
			if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(0, 3);
				s_axis_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				it = pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= it.data;
				s_axis_tlast <= it.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_cnt = 300;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rx_gap = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send(input logic [7:0] b, input logic l);
		comp_byte_t it;
		it.data = b;
		it.last = l;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_max(input logic [29:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One stream: well formed, corrupted, or plain noise.
	task automatic gen_stream(output int unsigned cnt);
		comp_byte_t  s [$];
		comp_byte_t  it;
		int unsigned mode;
		int unsigned total;
		int unsigned p;
		int unsigned n;
		int unsigned len;
		int unsigned off;
		int unsigned k;
		int unsigned kind;
		int unsigned v;
		mode = $urandom_range(0, 9);
		it.last = 1'b0;
		if (mode == 9) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				it.data = 8'($urandom);
				it.last = ($urandom_range(0, 7) == 0);
				s.insert(s.size(), it);
			end
		end else begin
			total = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 90);
			v = total;
			forever begin
				if (v < 128) begin
					it.data = 8'(v);
					s.insert(s.size(), it);
					break;
				end
				it.data = 8'(v & 'h7F) | 8'h80;
				s.insert(s.size(), it);
				v >>= 7;
			end
			p = 0;
			while (p < total) begin
				kind = (p == 0) ? 0 : $urandom_range(0, 3);
				if (kind == 1 && total - p < 4)
					kind = 2;
				if (kind == 0) begin
					n = $urandom_range(1, (total - p < 16) ? total - p : 16);
					if ($urandom_range(0, 3) == 0) begin
						it.data = 8'hF0;   // long literal, one length byte
						s.insert(s.size(), it);
						it.data = 8'(n - 1);
						s.insert(s.size(), it);
					end else begin
						it.data = 8'((n - 1) << 2);
						s.insert(s.size(), it);
					end
					repeat (n) begin
						it.data = 8'($urandom);
						s.insert(s.size(), it);
					end
					p += n;
				end else if (kind == 1) begin
					len = $urandom_range(4, (total - p < 11) ? total - p : 11);
					off = $urandom_range(1, (p < 2047) ? p : 2047);
					it.data = 8'(((off >> 8) << 5) | ((len - 4) << 2) | 1);
					s.insert(s.size(), it);
					it.data = 8'(off & 'hFF);
					s.insert(s.size(), it);
					p += len;
				end else begin
					len = $urandom_range(1, (total - p < 64) ? total - p : 64);
					off = $urandom_range(1, p);
					it.data = 8'(((len - 1) << 2) | kind);
					s.insert(s.size(), it);
					it.data = 8'(off & 'hFF);
					s.insert(s.size(), it);
					it.data = 8'(off >> 8);
					s.insert(s.size(), it);
					if (kind == 3) begin
						it.data = 8'd0;
						s.insert(s.size(), it);
						s.insert(s.size(), it);
					end
					p += len;
				end
			end
			if (mode >= 7 && s.size() > 1) begin
				k = $urandom_range(1, s.size() - 1);
				if (mode == 7)
					s = s[0:k-1];
				else
					s[k].data = 8'($urandom);
			end
		end
		s[$].last = 1'b1;
		foreach (s[i])
			pending_bytes.insert(pending_bytes.size(), s[i]);
		cnt = s.size();
		n_streams++;
	endtask

	task automatic random_phase(input int unsigned target);
		int unsigned sent;
		int unsigned c;
		sent = 0;
		while (sent < target) begin
			gen_stream(c);
			sent += c;
		end
	endtask

	initial begin
		max_len = 30'(MaxLenDefault);
		restart_stream();
		foreach (hist[i])
			hist[i] = 8'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty stream
		send(8'h00, 1);
		// literal with extreme bytes, then an overlapping copy
		send(8'h05, 0);
		send(8'h08, 0);
		send(8'h00, 0);
		send(8'hFF, 0);
		send(8'hA5, 0);
		send(8'h06, 0);
		send(8'h01, 0);
		send(8'h00, 1);
		// stream cut inside the header
		send(8'h80, 1);
		// ten-byte header, too large; trailing byte is drained
		repeat (10) send(8'hFF, 0);
		send(8'h00, 1);
		// zero copy offset
		send(8'h01, 0);
		send(8'h00, 0);
		send(8'h7A, 0);
		send(8'h01, 0);
		send(8'h00, 1);
		wait_idle();

		write_max(30'd0);
		random_phase(15);
		wait_idle();

		write_max(30'h3FFFFFFF);
		random_phase(50);
		wait_idle();

		write_max(30'd50);
		random_phase(40);
		wait_idle();

		write_max(30'(MaxLenDefault));
		hold_req = 1;
		random_phase(35);
		wait_idle();

		calm = 1;
		random_phase(35);
		wait_idle();

		$display("Ran %0d streams: %0d compressed items in, %0d output items checked.",
			n_streams, n_in, n_out);
		$display("Length limits tried: reset default, 0, 2^30-1 and 50.");
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
